// ===== rtl/sha1bs_pkg.sv =====
`default_nettype none
package sha1bs_pkg;
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;
   localparam int   FIFO_DEPTH  = 4;
   localparam int   FIFO_AW     = 2;
   localparam int   WORDS       = 5;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } item_type;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20)      k = 32'h5A827999;
      else if (r < 7'd40) k = 32'h6ED9EBA1;
      else if (r < 7'd60) k = 32'h8F1BBCDC;
      else                k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
      logic [31:0] f;
      if (r < 7'd20)      f = (b & c) | (~b & d);
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
      else                f = b ^ c ^ d;
      return f;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/sha1bs_front.sv =====
`default_nettype none
module sha1bs_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   output logic                 req_full,
   input  wire                  req_kind,
   input  wire  [7:0]           req_data_byte,
   output logic                 q_valid,
   output sha1bs_pkg::item_type q_item,
   input  wire                  q_take
);
   import sha1bs_pkg::*;

   item_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [FIFO_AW:0]   cnt_ff, cnt_in;
   logic               wr, rd;

   assign req_full = (cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = mem_ff[rp_ff];
   assign wr = req_push && !req_full;
   assign rd = q_take && q_valid;

   // pointer update
   always_comb begin
      wp_in  = wr ? wp_ff + 1'b1 : wp_ff;
      rp_in  = rd ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (FIFO_AW+1)'(wr) - (FIFO_AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= '{kind: req_kind, data_byte: req_data_byte};
      end
   end
endmodule
`default_nettype wire

// ===== rtl/sha1bs_back.sv =====
`default_nettype none
module sha1bs_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_valid,
   input  sha1bs_pkg::item_type q_item,
   output logic                 q_take,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output logic [31:0]          rsp_digest_word,
   output logic [2:0]           rsp_word_index,
   output logic                 rsp_last_word
);
   import sha1bs_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PAD  = 3'd1;
   localparam logic [2:0] S_COMP = 3'd2;
   localparam logic [2:0] S_ADD  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]  st_ff, st_in;
   logic [31:0] h_ff [WORDS];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] w_ff [16];
   logic [6:0]  rnd_ff;
   logic [5:0]  pos_ff;
   logic [63:0] bits_ff, total_ff;
   logic        fin_ff;
   logic        lenok_ff;
   logic [2:0]  oi_ff;
   logic [31:0] x, wnew, t;
   logic [63:0] len_sh;
   logic [7:0]  padb;
   logic        put, take_data, take_fin;
   logic [7:0]  putb;

   // schedule and round datapath
   always_comb begin
      x    = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      wnew = {x[30:0], x[31]};
      t = {a_ff[26:0], a_ff[31:27]} + round_f(rnd_ff, b_ff, c_ff, d_ff) + e_ff
          + round_k(rnd_ff) + w_ff[0];
   end

   // padding byte: 0x80 first, zeros, length big-endian in the length block
   assign len_sh = total_ff << {pos_ff[2:0], 3'b000};
   always_comb begin
      if (!fin_ff)                           padb = 8'h80;
      else if (lenok_ff && pos_ff >= 6'd56)  padb = len_sh[63:56];
      else                                   padb = 8'h00;
   end

   assign q_take    = (st_ff == S_IDLE) && q_valid;
   assign take_data = q_take && (q_item.kind == KIND_DATA);
   assign take_fin  = q_take && (q_item.kind == KIND_FINISH);
   assign put  = take_data || (st_ff == S_PAD);
   assign putb = (st_ff == S_PAD) ? padb : q_item.data_byte;

   assign rsp_empty       = (st_ff != S_EMIT);
   assign rsp_digest_word = h_ff[oi_ff];
   assign rsp_word_index  = oi_ff;
   assign rsp_last_word   = (oi_ff == 3'(WORDS - 1));

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (take_fin) st_in = S_PAD;
            else if (take_data && pos_ff == 6'd63) st_in = S_COMP;
         end
         S_PAD:  if (pos_ff == 6'd63) st_in = S_COMP;
         S_COMP: if (rnd_ff == 7'd79) st_in = S_ADD;
         S_ADD: begin
            if (!fin_ff) st_in = S_IDLE;
            else if (lenok_ff) st_in = S_EMIT;
            else st_in = S_PAD;
         end
         S_EMIT: if (rsp_pop && oi_ff == 3'(WORDS - 1)) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   // control state, counters and padding flags
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; pos_ff <= '0; bits_ff <= '0; total_ff <= '0;
         fin_ff <= 1'b0; lenok_ff <= 1'b0; oi_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (put) pos_ff <= pos_ff + 6'd1;
         if (take_data) bits_ff <= bits_ff + 64'd8;
         else if (st_ff == S_EMIT && st_in == S_IDLE) bits_ff <= '0;
         if (take_fin) total_ff <= bits_ff;
         // 0x80 placed once the first pad byte is written
         if (st_ff == S_PAD) fin_ff <= 1'b1;
         else if (st_ff == S_EMIT) fin_ff <= 1'b0;
         // length fits when 0x80 lands before byte 56, else in the next block
         if (st_ff == S_EMIT) lenok_ff <= 1'b0;
         else if ((st_ff == S_PAD && !fin_ff && pos_ff < 6'd56)
                  || (st_ff == S_ADD && fin_ff)) lenok_ff <= 1'b1;
         if (st_ff == S_EMIT && rsp_pop)
            oi_ff <= (oi_ff == 3'(WORDS - 1)) ? 3'd0 : oi_ff + 3'd1;
      end
   end

   // byte collection into the word window, then schedule shifting
   always_ff @(posedge clock) begin
      if (put) begin
         if (pos_ff[1:0] == 2'd0)
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= {w_ff[15][23:0], putb};
      end else if (st_ff == S_COMP) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnew;
      end
   end

   // one round per cycle
   always_ff @(posedge clock) begin
      if (st_in == S_COMP && st_ff != S_COMP) begin
         rnd_ff <= '0;
         a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
         d_ff <= h_ff[3]; e_ff <= h_ff[4];
      end else if (st_ff == S_COMP) begin
         rnd_ff <= rnd_ff + 7'd1;
         a_ff <= t; b_ff <= a_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff; e_ff <= d_ff;
      end
   end

   // chaining words: fold after each block, restart after the digest
   always_ff @(posedge clock) begin
      if (reset || (st_ff == S_EMIT && st_in == S_IDLE)) begin
         h_ff[0] <= IV0; h_ff[1] <= IV1; h_ff[2] <= IV2; h_ff[3] <= IV3;
         h_ff[4] <= IV4;
      end else if (st_ff == S_ADD) begin
         h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
         h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
         h_ff[4] <= h_ff[4] + e_ff;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/sha1_byte_stream_hasher_top.sv =====
// SHA-1 over a byte stream. Push a kind=0 transaction per message byte and a
// kind=1 transaction to finish; five digest words then appear, word 0 first,
// the fifth flagged last. Every 64th byte starts a compression (80 rounds at
// one per cycle plus the chain update) during which a 4-entry queue keeps
// taking bytes. Finish pads out the current block and compresses it; when
// 0x80 lands at byte 56 or later a second block of 64 pad bytes follows. The
// words then leave one per pop.
`default_nettype none
module sha1_byte_stream_hasher_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_push,
   output logic        req_full,
   input  wire         req_kind,
   input  wire  [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1bs_pkg::*;

   logic     q_valid, q_take;
   item_type q_item;

   sha1bs_front u_front (.clock, .reset, .req_push, .req_full, .req_kind,
      .req_data_byte, .q_valid, .q_item, .q_take);

   sha1bs_back u_back (.clock, .reset, .q_valid, .q_item, .q_take, .rsp_empty,
      .rsp_pop, .rsp_digest_word, .rsp_word_index, .rsp_last_word);
endmodule
`default_nettype wire

// ===== rtl/sha1bs_checker.sv =====
`default_nettype none
module sha1bs_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_empty,
   input wire        rsp_pop,
   input wire [2:0]  rsp_word_index,
   input wire        rsp_last_word
);
   // last flag only on the final word
   a_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last_word == (rsp_word_index == 3'd4)))
      else $error("last flag mismatch");
   // index advances after a pop of a non-last word
   a_next: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_word) |=>
      (!rsp_empty && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("word order broken");
   // index never beyond the digest
   a_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_word_index <= 3'd4)
      else $error("word index out of range");
endmodule

bind sha1_byte_stream_hasher_top sha1bs_checker u_chk (.clock, .reset,
   .rsp_empty, .rsp_pop, .rsp_word_index, .rsp_last_word);
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
import sha1bs_pkg::*;

// digest prediction and in-order checking of digest words
class digest_scoreboard;
   logic [31:0] chain [5];
   logic [7:0]  block [64];
   logic [63:0] bit_count;
   int          fill;
   logic [31:0] exp_word [$];
   logic [2:0]  exp_index [$];
   logic        exp_last [$];
   int          errors;
   int          words_seen;
   int          messages;

   function new();
      errors = 0;
      words_seen = 0;
      messages = 0;
      restart();
   endfunction

   function void restart();
      chain[0] = IV0; chain[1] = IV1; chain[2] = IV2; chain[3] = IV3; chain[4] = IV4;
      bit_count = '0;
      fill = 0;
   endfunction

   function logic [31:0] rol(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // 80-round compression of the block buffer into the chain
   function void compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
   endfunction

   function void add_byte(logic [7:0] v);
      block[fill] = v;
      fill = (fill + 1) % 64;
      if (fill == 0) compress();
   endfunction

   // note one accepted input transaction
   function void note_item(logic kind, logic [7:0] data);
      logic [63:0] total;
      if (kind == KIND_DATA) begin
         add_byte(data);
         bit_count += 64'd8;
      end else begin
         total = bit_count;
         add_byte(8'h80);
         while (fill != 56) add_byte(8'h00);
         for (int i = 0; i < 8; i++) add_byte(total[63 - 8*i -: 8]);
         for (int i = 0; i < 5; i++) begin
            exp_word.push_back(chain[i]);
            exp_index.push_back(3'(i));
            exp_last.push_back(i == 4);
         end
         messages++;
         restart();
      end
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   // check one accepted result transaction
   task check_word(logic [31:0] word, logic [2:0] idx, logic last);
      words_seen++;
      if (exp_word.size() == 0) begin
         report($sformatf("unexpected word %h", word));
         return;
      end
      if (word !== exp_word[0])
         report($sformatf("digest_word %h, expected %h", word, exp_word[0]));
      if (idx !== exp_index[0])
         report($sformatf("word_index %0d, expected %0d", idx, exp_index[0]));
      if (last !== exp_last[0])
         report($sformatf("last_word %b, expected %b", last, exp_last[0]));
      void'(exp_word.pop_front());
      void'(exp_index.pop_front());
      void'(exp_last.pop_front());
   endtask

   function int pending();
      return exp_word.size();
   endfunction
endclass

module testbench;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_kind = KIND_DATA;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_pop = 1'b0;
   wire         req_full;
   wire         rsp_empty;
   wire  [31:0] rsp_digest_word;
   wire  [2:0]  rsp_word_index;
   wire         rsp_last_word;

   localparam int WATCHDOG_LIMIT = 20000;

   digest_scoreboard board = new();
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int quiet_cycles = 0;
   bit timed_out = 0;

   sha1_byte_stream_hasher_top dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_kind(req_kind), .req_data_byte(req_data_byte),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   always #5 clock = ~clock;

   // result side: random stalls, check on accept
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         board.check_word(rsp_digest_word, rsp_word_index, rsp_last_word);
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("watchdog expired, %0d words outstanding", board.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   // send one transaction, with random idle cycles before it
   task automatic send_item(logic kind, logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_kind <= kind;
      req_data_byte <= data;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_item(kind, data);
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++) send_item(KIND_DATA, 8'($urandom_range(255)));
      send_item(KIND_FINISH, 8'($urandom_range(255)));
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, extreme bytes
      send_item(KIND_FINISH, 8'hFF);
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_FINISH, 8'h00);
      drain();

      // phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 52 : ((phase == 3) ? 14 : 0);
         pop_stall_pct = (phase == 2) ? 52 : ((phase == 3) ? 14 : 0);
         send_message($urandom_range(2));
         // one full data block, then 56 bytes whose padding spills into a third block
         if (phase == 3) send_message(120);
         drain();
      end

      repeat (400) @(posedge clock);
      $display("hashed %0d messages, checked %0d digest words",
               board.messages, board.words_seen);
      $display("covered empty, short and multi-block messages under stalls");
      if (board.errors == 0 && board.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== sha1_byte_stream_hasher_top.f =====
rtl/sha1bs_pkg.sv
rtl/sha1bs_front.sv
rtl/sha1bs_back.sv
rtl/sha1_byte_stream_hasher_top.sv
rtl/sha1bs_checker.sv
dv/testbench.sv
